// ===== hw/rtl/dswm_pkg.sv =====
// Shared types and codes for the disjoint-set block with move.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dswm_pkg;

    localparam int MODE_W = 2;
    localparam int ELEM_W = 10;
    localparam int SIZE_W = 11;
    localparam int SUM_W  = 19;

    localparam logic [MODE_W-1:0] MODE_UNION  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MOVE   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [ELEM_W-1:0] elem_a;
        logic [ELEM_W-1:0] elem_b;
    } t_in;

    typedef struct packed {
        logic [SIZE_W-1:0] set_size;
        logic [SUM_W-1:0]  set_sum;
    } t_out;

endpackage

`default_nettype wire

// ===== hw/rtl/dswm_cell.sv =====
// One cell of the rotating state ring: label, count and sum of one entry.
// Depends on nothing; instantiated by disjoint_set_with_move.
`timescale 1ns / 1ps
`default_nettype none

module dswm_cell #(
    parameter int IDX_W = 10,
    parameter int CNT_W = 11,
    parameter int SUM_W = 20,
    parameter int INIT  = 0
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_shift,
    input  wire logic [IDX_W-1:0] i_label,
    input  wire logic [CNT_W-1:0] i_count,
    input  wire logic [SUM_W-1:0] i_sum,
    output logic      [IDX_W-1:0] o_label,
    output logic      [CNT_W-1:0] o_count,
    output logic      [SUM_W-1:0] o_sum
);

    logic [IDX_W-1:0] r_label;
    logic [CNT_W-1:0] r_count;
    logic [SUM_W-1:0] r_sum;

    // reset value: entry stands alone in its own set
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_label <= IDX_W'(INIT);
            r_count <= CNT_W'(1);
            r_sum   <= SUM_W'(INIT);
        end else if (i_shift) begin
            r_label <= i_label;
            r_count <= i_count;
            r_sum   <= i_sum;
        end
    end

    assign o_label = r_label;
    assign o_count = r_count;
    assign o_sum   = r_sum;

endmodule

`default_nettype wire

// ===== hw/rtl/disjoint_set_with_move.sv =====
// A union makes three passes (find, gather, apply), a move two (find, apply), a query
// two (find, gather) and a result step; a union or move within one set stops after find.
// One item at a time; mode 3 or out-of-range items are dropped. Each pass rotates the N-cell
// ring once past the head logic. Reset (synchronous, active low) puts every element alone in
// its own set at once. No clearing pass is needed: every cell resets in place.
`timescale 1ns / 1ps
`default_nettype none

module disjoint_set_with_move #(
    parameter int N_ELEMENTS = 1024
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire dswm_pkg::t_in  i_in,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output dswm_pkg::t_out      o_out
);

    localparam int IDX_W = $clog2(N_ELEMENTS);
    localparam int CNT_W = $clog2(N_ELEMENTS + 1);
    // sum of all element numbers stays below 2^(2*IDX_W)
    localparam int SUM_W = 2 * IDX_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,     // pass 1: pick up labels of a and b
        S_GATHER,   // pass 2: pick up count and sum of a's label
        S_APPLY,    // pass 3: relabel and fix counts and sums
        S_RESULT    // hand query result to the output register
    } t_state;

    // ring: cell k feeds cell k+1, last cell returns through the head logic to cell 0.
    // The entry in the last cell has index r_pos.
    logic [IDX_W-1:0] w_label [N_ELEMENTS];
    logic [CNT_W-1:0] w_count [N_ELEMENTS];
    logic [SUM_W-1:0] w_sum   [N_ELEMENTS];

    logic [IDX_W-1:0] wb_label;
    logic [CNT_W-1:0] wb_count;
    logic [SUM_W-1:0] wb_sum;
    logic             w_shift;

    for (genvar k = 0; k < N_ELEMENTS; k++) begin : g_ring
        // at pass alignment, the last cell holds entry 0, the first holds entry N-1
        dswm_cell #(
            .IDX_W (IDX_W),
            .CNT_W (CNT_W),
            .SUM_W (SUM_W),
            .INIT  (N_ELEMENTS - 1 - k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_label ((k == 0) ? wb_label : w_label[(k == 0) ? 0 : k - 1]),
            .i_count ((k == 0) ? wb_count : w_count[(k == 0) ? 0 : k - 1]),
            .i_sum   ((k == 0) ? wb_sum   : w_sum[(k == 0) ? 0 : k - 1]),
            .o_label (w_label[k]),
            .o_count (w_count[k]),
            .o_sum   (w_sum[k])
        );
    end

    logic [IDX_W-1:0] w_tail_label;
    logic [CNT_W-1:0] w_tail_count;
    logic [SUM_W-1:0] w_tail_sum;

    assign w_tail_label = w_label[N_ELEMENTS-1];
    assign w_tail_count = w_count[N_ELEMENTS-1];
    assign w_tail_sum   = w_sum[N_ELEMENTS-1];

    // control and operand registers
    t_state                   r_state, n_state;
    logic [IDX_W-1:0]         r_pos, n_pos;
    logic [dswm_pkg::MODE_W-1:0] r_mode, n_mode;
    logic [IDX_W-1:0]         r_a, n_a;
    logic [IDX_W-1:0]         r_b, n_b;
    logic [IDX_W-1:0]         r_la, n_la;
    logic [IDX_W-1:0]         r_lb, n_lb;
    logic [CNT_W-1:0]         r_cnt_la, n_cnt_la;
    logic [SUM_W-1:0]         r_sum_la, n_sum_la;
    logic                     r_out_valid, n_out_valid;
    dswm_pkg::t_out           r_out, n_out;

    logic w_at_end;
    logic w_a_ok;
    logic w_b_ok;
    logic w_is_union;
    logic w_is_move;
    logic w_is_query;

    assign w_at_end   = (r_pos == IDX_W'(N_ELEMENTS - 1));
    assign w_a_ok     = (32'(i_in.elem_a) < 32'(N_ELEMENTS));
    assign w_b_ok     = (32'(i_in.elem_b) < 32'(N_ELEMENTS));
    assign w_is_union = (r_mode == dswm_pkg::MODE_UNION);
    assign w_is_move  = (r_mode == dswm_pkg::MODE_MOVE);
    assign w_is_query = (r_mode == dswm_pkg::MODE_QUERY);

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_mode      = r_mode;
        n_a         = r_a;
        n_b         = r_b;
        n_la        = r_la;
        n_lb        = r_lb;
        n_cnt_la    = r_cnt_la;
        n_sum_la    = r_sum_la;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        wb_label    = w_tail_label;
        wb_count    = w_tail_count;
        wb_sum      = w_tail_sum;
        w_shift     = (r_state == S_FIND) || (r_state == S_GATHER) || (r_state == S_APPLY);

        if (w_shift) begin
            n_pos = w_at_end ? '0 : r_pos + IDX_W'(1);
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_mode = i_in.mode;
                    n_a    = IDX_W'(i_in.elem_a);
                    n_b    = IDX_W'(i_in.elem_b);
                    // unused mode or element out of range: drop the transfer
                    if (i_in.mode == dswm_pkg::MODE_QUERY) begin
                        if (w_a_ok) begin
                            n_state = S_FIND;
                        end
                    end else if (i_in.mode == dswm_pkg::MODE_UNION
                                 || i_in.mode == dswm_pkg::MODE_MOVE) begin
                        if (w_a_ok && w_b_ok) begin
                            n_state = S_FIND;
                        end
                    end
                end
            end
            S_FIND: begin
                if (r_pos == r_a) begin
                    n_la = w_tail_label;
                end
                if (r_pos == r_b) begin
                    n_lb = w_tail_label;
                end
                if (w_at_end) begin
                    if (w_is_query) begin
                        n_state = S_GATHER;
                    end else if (n_la == n_lb) begin
                        n_state = S_IDLE;   // same set: nothing changes
                    end else if (w_is_union) begin
                        n_state = S_GATHER;
                    end else begin
                        n_state = S_APPLY;
                    end
                end
            end
            S_GATHER: begin
                if (r_pos == r_la) begin
                    n_cnt_la = w_tail_count;
                    n_sum_la = w_tail_sum;
                end
                if (w_at_end) begin
                    n_state = w_is_query ? S_RESULT : S_APPLY;
                end
            end
            S_APPLY: begin
                if (w_is_union) begin
                    if (w_tail_label == r_la) begin
                        wb_label = r_lb;
                    end
                    if (r_pos == r_la) begin
                        wb_count = '0;
                        wb_sum   = '0;
                    end else if (r_pos == r_lb) begin
                        wb_count = w_tail_count + r_cnt_la;
                        wb_sum   = w_tail_sum + r_sum_la;
                    end
                end else if (w_is_move) begin
                    if (r_pos == r_a) begin
                        wb_label = r_lb;
                    end
                    if (r_pos == r_la) begin
                        wb_count = w_tail_count - CNT_W'(1);
                        wb_sum   = w_tail_sum - SUM_W'(r_a);
                    end else if (r_pos == r_lb) begin
                        wb_count = w_tail_count + CNT_W'(1);
                        wb_sum   = w_tail_sum + SUM_W'(r_a);
                    end
                end
                if (w_at_end) begin
                    n_state = S_IDLE;
                end
            end
            S_RESULT: begin
                // wait for the output register to free up
                if (!r_out_valid || i_out_ready) begin
                    n_out.set_size = dswm_pkg::SIZE_W'(r_cnt_la);
                    n_out.set_sum  = dswm_pkg::SUM_W'(r_sum_la);
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
        r_mode   <= n_mode;
        r_a      <= n_a;
        r_b      <= n_b;
        r_la     <= n_la;
        r_lb     <= n_lb;
        r_cnt_la <= n_cnt_la;
        r_sum_la <= n_sum_la;
        r_out    <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

// ===== hw/rtl/dswm_chk.sv =====
// Port-level checks for disjoint_set_with_move, attached by bind.
// Depends on dswm_pkg and the top level's port list.
`timescale 1ns / 1ps
`default_nettype none

module dswm_chk #(
    parameter int N_ELEMENTS = 1024
) (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_in_valid,
    input wire logic           o_in_ready,
    input wire dswm_pkg::t_in  i_in,
    input wire logic           o_out_valid,
    input wire logic           i_out_ready,
    input wire dswm_pkg::t_out o_out
);

    logic w_in_xfer;
    logic w_ab_ok;

    assign w_in_xfer = i_in_valid && o_in_ready;
    assign w_ab_ok   = (32'(i_in.elem_a) < 32'(N_ELEMENTS))
                    && (32'(i_in.elem_b) < 32'(N_ELEMENTS));

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed or dropped while stalled");

    // a valid union takes the block out of ready after its transfer
    a_union_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer && i_in.mode == dswm_pkg::MODE_UNION && w_ab_ok |=> !o_in_ready)
        else $error("union did not start a pass");

    // a result appears only at the end of work, never out of idle
    a_out_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result produced without a query in progress");

    // an unused mode gives no result and keeps the block ready
    a_unused_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer && i_in.mode == dswm_pkg::MODE_UNUSED |=> o_in_ready && !$rose(o_out_valid))
        else $error("unused mode was not dropped");

endmodule

bind disjoint_set_with_move dswm_chk #(.N_ELEMENTS(N_ELEMENTS)) u_dswm_chk (.*);

`default_nettype wire

// ===== tb/sv/disjoint_set_with_move_tb.sv =====
// Self-checking bench for disjoint_set_with_move: a directed opening, then random
// union, move, query and unused-mode traffic, each query answer checked against a local partition.
// Depends on dswm_pkg (hw/rtl/dswm_pkg.sv) and the disjoint_set_with_move RTL.
`timescale 1ns / 1ps

module disjoint_set_with_move_tb;

    localparam int N_ELEM       = 1024;
    localparam int CLK_HALF     = 2;
    localparam int RESET_CYCLES = 12;
    // A union walks the label ring three times, the slowest item the block takes.
    localparam int SETTLE_CYCLES = 3 * N_ELEM + 16;
    localparam int RANDOM_OPS    = 530;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_in_valid = 1'b0;
    logic           o_in_ready;
    dswm_pkg::t_in  i_in = '0;
    logic           o_out_valid;
    logic           i_out_ready = 1'b0;
    dswm_pkg::t_out o_out;

    disjoint_set_with_move #(
        .N_ELEMENTS(N_ELEM)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Local copy of the partition: a label per element, and per label the
    // member count and the sum of member numbers.
    // ------------------------------------------------------------------
    logic [dswm_pkg::ELEM_W-1:0] elem_label [N_ELEM];
    logic [dswm_pkg::SIZE_W-1:0] label_members [N_ELEM];
    logic [19:0]                 label_total [N_ELEM];

    dswm_pkg::t_in  op_backlog [$];     // items waiting for the driver
    dswm_pkg::t_out query_answers [$];  // answers owed by the block, oldest first

    int ops_sent = 0;
    int answers_seen = 0;
    int mismatches = 0;

    function automatic void reset_partition();
        for (int i = 0; i < N_ELEM; i++) begin
            elem_label[i]    = dswm_pkg::ELEM_W'(i);
            label_members[i] = dswm_pkg::SIZE_W'(1);
            label_total[i]   = 20'(i);
        end
    endfunction

    // Apply one transferred item to the local partition; a query owes one answer.
    function automatic void apply_partition_op(input dswm_pkg::t_in op);
        logic [dswm_pkg::ELEM_W-1:0] from_label;
        logic [dswm_pkg::ELEM_W-1:0] to_label;
        dswm_pkg::t_out answer;
        from_label = elem_label[op.elem_a];
        to_label   = elem_label[op.elem_b];
        case (op.mode)
            dswm_pkg::MODE_QUERY: begin
                answer.set_size = label_members[from_label];
                answer.set_sum  = label_total[from_label][dswm_pkg::SUM_W-1:0];
                query_answers.push_back(answer);
            end
            dswm_pkg::MODE_UNION: begin
                // Same set: nothing changes.
                if (from_label != to_label) begin
                    for (int i = 0; i < N_ELEM; i++)
                        if (elem_label[i] == from_label)
                            elem_label[i] = to_label;
                    label_members[to_label] += label_members[from_label];
                    label_total[to_label]   += label_total[from_label];
                    // The old label is left empty and never reused.
                    label_members[from_label] = '0;
                    label_total[from_label]   = '0;
                end
            end
            dswm_pkg::MODE_MOVE: begin
                // Only a leaves; its old set mates keep their label.
                if (from_label != to_label) begin
                    elem_label[op.elem_a] = to_label;
                    label_members[from_label] -= dswm_pkg::SIZE_W'(1);
                    label_total[from_label]   -= 20'(op.elem_a);
                    label_members[to_label]   += dswm_pkg::SIZE_W'(1);
                    label_total[to_label]     += 20'(op.elem_a);
                end
            end
            default: ;  // unused mode: ignored, no answer
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    task automatic queue_op(input logic [dswm_pkg::MODE_W-1:0] mode, input int a, input int b);
        dswm_pkg::t_in op;
        op.mode   = mode;
        op.elem_a = dswm_pkg::ELEM_W'(a);
        op.elem_b = dswm_pkg::ELEM_W'(b);
        op_backlog.push_back(op);
    endtask

    // Most operands come from a small pool so that sets grow, collide and
    // split; the rest span the full element range.
    function automatic int pick_elem();
        if ($urandom_range(0, 99) < 60)
            return $urandom_range(0, 47);
        return $urandom_range(0, N_ELEM - 1);
    endfunction

    // ------------------------------------------------------------------
    // Driver: presents backlog items, holds each until its transfer, and
    // updates the local partition at the transfer edge. Transfers 150..249
    // go through with no gaps.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                apply_partition_op(i_in);
                ops_sent++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (op_backlog.size() != 0 &&
                    ((ops_sent >= 150 && ops_sent < 250) || $urandom_range(0, 99) >= 33)) begin
                    i_in       <= op_backlog.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random back-pressure on the result side, except for answers
    // 60..99, and a field-by-field check of every result transfer.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (query_answers.size() == 0) begin
                    report_mismatch("result with no query pending, set_size",
                                    int'(o_out.set_size), 0);
                end else begin
                    dswm_pkg::t_out want;
                    want = query_answers.pop_front();
                    if (o_out.set_size !== want.set_size)
                        report_mismatch("set_size", int'(o_out.set_size), int'(want.set_size));
                    if (o_out.set_sum !== want.set_sum)
                        report_mismatch("set_sum", int'(o_out.set_sum), int'(want.set_sum));
                end
                answers_seen++;
            end
            i_out_ready <= (answers_seen >= 60 && answers_seen < 100) ||
                           ($urandom_range(0, 99) >= 33);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------
    initial begin
        int counted;
        int pick;
        reset_partition();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening: field extremes, every mode, the no-op cases.
        queue_op(dswm_pkg::MODE_QUERY, 0, 0);
        queue_op(dswm_pkg::MODE_QUERY, N_ELEM - 1, N_ELEM - 1);
        queue_op(dswm_pkg::MODE_UNION, 0, N_ELEM - 1);    // 0 joins 1023's set
        queue_op(dswm_pkg::MODE_QUERY, 0, 0);
        queue_op(dswm_pkg::MODE_QUERY, N_ELEM - 1, 0);
        queue_op(dswm_pkg::MODE_MOVE, 5, N_ELEM - 1);     // 5 into {0, 1023}
        queue_op(dswm_pkg::MODE_QUERY, 5, 682);
        queue_op(dswm_pkg::MODE_MOVE, N_ELEM - 1, 7);     // label owner leaves, mates stay
        queue_op(dswm_pkg::MODE_QUERY, 0, 0);
        queue_op(dswm_pkg::MODE_QUERY, 7, 0);
        queue_op(dswm_pkg::MODE_UNION, 0, 5);             // same set: no change
        queue_op(dswm_pkg::MODE_MOVE, 5, 0);              // same set: no change
        queue_op(dswm_pkg::MODE_UNION, 9, 9);             // a equals b
        queue_op(dswm_pkg::MODE_MOVE, 341, 341);
        queue_op(dswm_pkg::MODE_UNUSED, 682, 341);        // unused mode: dropped
        queue_op(dswm_pkg::MODE_UNUSED, N_ELEM - 1, N_ELEM - 1);
        queue_op(dswm_pkg::MODE_QUERY, 0, 0);
        queue_op(dswm_pkg::MODE_MOVE, 0, 5);              // empties nothing: same set
        queue_op(dswm_pkg::MODE_MOVE, 0, 7);              // leaves 5 alone under label 1023
        queue_op(dswm_pkg::MODE_QUERY, 5, 0);
        queue_op(dswm_pkg::MODE_UNION, 7, 5);             // {0,7,1023} into 5's set
        queue_op(dswm_pkg::MODE_QUERY, N_ELEM - 1, 0);
        queue_op(dswm_pkg::MODE_QUERY, 682, 1023);

        counted = 0;
        while (counted < RANDOM_OPS) begin
            // Halfway through, hold the sender until every answer is in.
            if (counted == RANDOM_OPS / 2) begin
                while (op_backlog.size() != 0 || i_in_valid || query_answers.size() != 0)
                    @(posedge i_clk);
            end
            pick = $urandom_range(0, 99);
            if (pick < 28) begin
                queue_op(dswm_pkg::MODE_UNION, pick_elem(), pick_elem());
                counted++;
            end else if (pick < 56) begin
                queue_op(dswm_pkg::MODE_MOVE, pick_elem(), pick_elem());
                counted++;
            end else if (pick < 95) begin
                queue_op(dswm_pkg::MODE_QUERY, pick_elem(), $urandom_range(0, N_ELEM - 1));
                counted++;
            end else begin
                queue_op(dswm_pkg::MODE_UNUSED, pick_elem(), pick_elem());
            end
        end

        while (op_backlog.size() != 0 || i_in_valid || query_answers.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("disjoint_set_with_move_tb: PASS");
        end else begin
            $display("disjoint_set_with_move_tb: FAIL");
        end
        $finish;
    end

    // Run limit: a run that has not finished by this time ends as a failure.
    initial begin
        #40_000_000;
        $display("disjoint_set_with_move_tb: FAIL");
        $finish;
    end

endmodule
